@@ rtl/core/oasd_pkg.sv @@
// Package for the obstacle avoidance steering decider.
// Holds command, direction and register index codes; depends on nothing.
package oasd_pkg;

    localparam int unsigned DistW  = 16;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned CountW = 5;
    localparam int unsigned WinW   = 16;
    localparam int unsigned CmdW   = 3;
    localparam int unsigned FlagW  = 3;
    localparam int unsigned DirW   = 2;
    localparam int unsigned IdxW   = 3;

    typedef logic [DistW-1:0]  t_dist;
    typedef logic [TimeW-1:0]  t_time;
    typedef logic [CountW-1:0] t_count;
    typedef logic [CmdW-1:0]   t_cmd;
    typedef logic [FlagW-1:0]  t_flags;
    typedef logic [DirW-1:0]   t_dir;
    typedef logic [IdxW-1:0]   t_cfg_idx;

    localparam t_dir DIR_FORWARD  = 2'd0;
    localparam t_dir DIR_LEFT     = 2'd1;
    localparam t_dir DIR_RIGHT    = 2'd2;
    localparam t_dir DIR_BACKWARD = 2'd3;

    localparam t_cmd CMD_ESTOP    = 3'd0;
    localparam t_cmd CMD_BACKWARD = 3'd4;

    localparam t_count COUNT_MAX = 5'd31;

    localparam t_cfg_idx CFG_SAFE      = 3'd0;
    localparam t_cfg_idx CFG_WARNING   = 3'd1;
    localparam t_cfg_idx CFG_EMERGENCY = 3'd2;
    localparam t_cfg_idx CFG_WINDOW    = 3'd3;
    localparam t_cfg_idx CFG_LIMIT     = 3'd4;

    localparam t_dist  RST_SAFE      = 16'd300;
    localparam t_dist  RST_WARNING   = 16'd200;
    localparam t_dist  RST_EMERGENCY = 16'd100;
    localparam t_dist  RST_WINDOW    = 16'd5000;
    localparam t_count RST_LIMIT     = 5'd8;

endpackage

@@ rtl/core/obstacle_avoid_steering_decider.sv @@
// Top level of the obstacle avoidance steering decider.
// Uses oasd_pkg for codes and types; no submodules.
//
// Channel   Direction  Handshake                  Payload
// in        sink       i_in_valid / o_in_ready    front, left, right distance, now_ms
// out       source     o_out_valid / i_out_ready  command, obstacle_flags
// cfg       sink       i_cfg_valid / o_cfg_ready  cfg_index, cfg_data
//
// A word is held in the input register and then moves to the result register once that
// register is free or being read; one word is taken per cycle while the output is not stalled.
// The loop state updates as a word moves from the input to the result register, unless the word is an emergency stop.
// Reset clears the valid flags and loop state and loads default config; data is not reset.
// A stalled output holds the pipeline; ready falls only when both stages are full.
module obstacle_avoid_steering_decider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  oasd_pkg::t_dist            i_front_distance,
    input  oasd_pkg::t_dist            i_left_distance,
    input  oasd_pkg::t_dist            i_right_distance,
    input  oasd_pkg::t_time            i_now_ms,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output oasd_pkg::t_cmd             o_command,
    output oasd_pkg::t_flags           o_obstacle_flags,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  oasd_pkg::t_cfg_idx         i_cfg_index,
    input  oasd_pkg::t_dist            i_cfg_data
);
    import oasd_pkg::*;

    t_dist  r_safe, r_warning, r_emergency, r_window;
    t_count r_limit;

    t_dir   r_last_dir;
    t_count r_same_count;
    t_time  r_last_change;

    logic   r_s1_valid;
    t_dist  r_s1_front, r_s1_left, r_s1_right;
    t_time  r_s1_now;

    logic   r_out_valid;
    t_cmd   r_out_command;
    t_flags r_out_flags;

    logic   advance;
    t_dist  half;
    t_flags n_flags;
    logic   estop;
    t_dir   n_dir;
    t_time  elapsed;
    logic   timeout;
    t_count base_count;
    t_count n_same_count;
    t_time  n_last_change;
    t_cmd   n_command;

    assign advance     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_command        = r_out_command;
    assign o_obstacle_flags = r_out_flags;

    always_comb begin
        half    = r_emergency >> 1;
        n_flags = {r_s1_right < r_warning, r_s1_left < r_warning, r_s1_front < r_warning};
        estop   = (r_s1_front < r_emergency) || (r_s1_left < half) || (r_s1_right < half);

        if (r_s1_front > r_safe) begin
            if (r_s1_left < r_warning && r_s1_right > r_safe) begin
                n_dir = DIR_RIGHT;
            end else if (r_s1_right < r_warning && r_s1_left > r_safe) begin
                n_dir = DIR_LEFT;
            end else begin
                n_dir = DIR_FORWARD;
            end
        end else if (r_s1_left > r_s1_right && r_s1_left > r_warning) begin
            n_dir = DIR_LEFT;
        end else if (r_s1_right > r_warning) begin
            n_dir = DIR_RIGHT;
        end else begin
            n_dir = DIR_BACKWARD;
        end

        elapsed    = r_s1_now - r_last_change;
        timeout    = elapsed > {{(TimeW-WinW){1'b0}}, r_window};
        base_count = timeout ? '0 : r_same_count;

        if (n_dir == r_last_dir) begin
            n_same_count  = (base_count == COUNT_MAX) ? COUNT_MAX : base_count + 5'd1;
            n_last_change = r_last_change;
        end else begin
            n_same_count  = '0;
            n_last_change = r_s1_now;
        end

        if (estop) begin
            n_command = CMD_ESTOP;
        end else if (n_same_count > r_limit) begin
            n_command = CMD_BACKWARD;
        end else begin
            n_command = {1'b0, n_dir} + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_safe      <= RST_SAFE;
            r_warning   <= RST_WARNING;
            r_emergency <= RST_EMERGENCY;
            r_window    <= RST_WINDOW;
            r_limit     <= RST_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SAFE:      r_safe      <= i_cfg_data;
                CFG_WARNING:   r_warning   <= i_cfg_data;
                CFG_EMERGENCY: r_emergency <= i_cfg_data;
                CFG_WINDOW:    r_window    <= i_cfg_data;
                CFG_LIMIT:     r_limit     <= i_cfg_data[CountW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_last_dir    <= DIR_FORWARD;
            r_same_count  <= '0;
            r_last_change <= '0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance && !estop) begin
                r_last_dir    <= n_dir;
                r_same_count  <= n_same_count;
                r_last_change <= n_last_change;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_front <= i_front_distance;
            r_s1_left  <= i_left_distance;
            r_s1_right <= i_right_distance;
            r_s1_now   <= i_now_ms;
        end
        if (advance) begin
            r_out_command <= n_command;
            r_out_flags   <= n_flags;
        end
    end

    a_estop_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && estop |=> $stable(r_same_count) && $stable(r_last_dir)
            && $stable(r_last_change))
        else $error("Emergency stop changed the loop state.");

    a_turn_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !estop && (n_dir != r_last_dir) |=> r_same_count == '0)
        else $error("Direction change did not clear the repeat count.");

    a_full_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("Input accepted while both stages are stalled.");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out_command)
            && $stable(r_out_flags))
        else $error("Stalled result was lost or changed.");

endmodule

@@ verif/oasd_steering_checker.sv @@
`timescale 1ns / 1ps
// Checker for the obstacle avoidance steering decider: watches the input, result and
// register channels, predicts each result word and compares it field by field.
// Depends on oasd_pkg for types, codes and register reset values.
module oasd_steering_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  oasd_pkg::t_dist      i_front_distance,
    input  oasd_pkg::t_dist      i_left_distance,
    input  oasd_pkg::t_dist      i_right_distance,
    input  oasd_pkg::t_time      i_now_ms,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  oasd_pkg::t_cmd       i_command,
    input  oasd_pkg::t_flags     i_obstacle_flags,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  oasd_pkg::t_cfg_idx   i_cfg_index,
    input  oasd_pkg::t_dist      i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    import oasd_pkg::*;

    localparam t_cmd CMD_FORWARD = 3'd1;
    localparam t_cmd CMD_LEFT    = 3'd2;
    localparam t_cmd CMD_RIGHT   = 3'd3;

    typedef struct packed {
        t_cmd   command;
        t_flags flags;
    } t_steer;

    t_dist  safe_mm;
    t_dist  warn_mm;
    t_dist  emerg_mm;
    t_dist  window_ms;
    t_count stuck_limit;

    t_dir   last_dir;
    t_count repeat_cnt;
    t_time  change_ms;

    t_steer steer_q[$];

    function automatic t_dir choose_direction(input t_dist f, input t_dist l, input t_dist r);
        if (f > safe_mm) begin
            if (l < warn_mm && r > safe_mm) return DIR_RIGHT;
            if (r < warn_mm && l > safe_mm) return DIR_LEFT;
            return DIR_FORWARD;
        end
        if (l > r && l > warn_mm) return DIR_LEFT;
        if (r > warn_mm) return DIR_RIGHT;
        return DIR_BACKWARD;
    endfunction

    // Updates the loop state unless the word ends in an emergency stop.
    function automatic t_steer decide_steering(input t_dist f, input t_dist l, input t_dist r,
                                               input t_time now);
        t_steer res;
        t_dir   dir;
        t_dist  half;
        t_time  since;
        half = emerg_mm >> 1;
        res.flags = {r < warn_mm, l < warn_mm, f < warn_mm};
        if (f < emerg_mm || l < half || r < half) begin
            res.command = CMD_ESTOP;
            return res;
        end
        dir = choose_direction(f, l, r);
        since = now - change_ms;
        if (since > {16'b0, window_ms}) repeat_cnt = '0;
        if (dir == last_dir) begin
            if (repeat_cnt != COUNT_MAX) repeat_cnt = repeat_cnt + 1'b1;
        end else begin
            repeat_cnt = '0;
            change_ms = now;
        end
        last_dir = dir;
        if (repeat_cnt > stuck_limit) begin
            res.command = CMD_BACKWARD;
        end else begin
            case (dir)
                DIR_FORWARD: res.command = CMD_FORWARD;
                DIR_LEFT:    res.command = CMD_LEFT;
                DIR_RIGHT:   res.command = CMD_RIGHT;
                default:     res.command = CMD_BACKWARD;
            endcase
        end
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin : monitor
        t_steer want;
        if (!i_rst_n) begin
            safe_mm = RST_SAFE;
            warn_mm = RST_WARNING;
            emerg_mm = RST_EMERGENCY;
            window_ms = RST_WINDOW;
            stuck_limit = RST_LIMIT;
            last_dir = DIR_FORWARD;
            repeat_cnt = '0;
            change_ms = '0;
            steer_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SAFE:      safe_mm = i_cfg_data;
                    CFG_WARNING:   warn_mm = i_cfg_data;
                    CFG_EMERGENCY: emerg_mm = i_cfg_data;
                    CFG_WINDOW:    window_ms = i_cfg_data;
                    CFG_LIMIT:     stuck_limit = i_cfg_data[CountW-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (steer_q.size() == 0) begin
                    $error("unexpected result word: command %0d, flags %0d",
                           i_command, i_obstacle_flags);
                    o_fail_count++;
                end else begin
                    want = steer_q.pop_front();
                    if (i_command !== want.command) begin
                        $error("command: expected %0d, got %0d", want.command, i_command);
                        o_fail_count++;
                    end
                    if (i_obstacle_flags !== want.flags) begin
                        $error("obstacle_flags: expected %0d, got %0d",
                               want.flags, i_obstacle_flags);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                steer_q.push_back(decide_steering(i_front_distance, i_left_distance,
                                                  i_right_distance, i_now_ms));
            end
        end
        o_pending = steer_q.size();
    end

endmodule

@@ verif/tb_obstacle_avoid_steering_decider.sv @@
`timescale 1ns / 1ps
// Testbench top for the obstacle avoidance steering decider: clock, reset, stimulus
// on the input, result and register channels, and the verdict.
// Depends on oasd_pkg, the block itself and oasd_steering_checker.
module tb_obstacle_avoid_steering_decider;

    import oasd_pkg::*;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    t_dist    front_mm;
    t_dist    left_mm;
    t_dist    right_mm;
    t_time    now_ms;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_cmd     command;
    t_flags   obstacle_flags;
    logic     cfg_valid;
    logic     cfg_ready;
    t_cfg_idx cfg_index;
    t_dist    cfg_data;

    int       fail_count;
    int       pending;
    int       send_idle_pct;
    int       recv_idle_pct = 0;
    int       hold_left = 0;
    bit       long_hold_req = 1'b0;
    t_time    ms_clock;
    t_dist    cur_safe;
    t_dist    cur_warn;
    t_dist    cur_emerg;
    t_dist    cur_window;

    obstacle_avoid_steering_decider u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_front_distance (front_mm),
        .i_left_distance  (left_mm),
        .i_right_distance (right_mm),
        .i_now_ms         (now_ms),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_command        (command),
        .o_obstacle_flags (obstacle_flags),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    oasd_steering_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_front_distance (front_mm),
        .i_left_distance  (left_mm),
        .i_right_distance (right_mm),
        .i_now_ms         (now_ms),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_command        (command),
        .i_obstacle_flags (obstacle_flags),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always #5 clk = ~clk;

    // The receiver either serves a requested long hold-off or stalls at random.
    always @(negedge clk) begin
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = 80;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_reading(input t_dist f, input t_dist l, input t_dist r,
                                input t_time now);
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        front_mm <= f;
        left_mm <= l;
        right_mm <= r;
        now_ms <= now;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_dist data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_phase(input int ph);
        t_dist lim_data;
        case (ph)
            0: begin
                cur_safe = RST_SAFE; cur_warn = RST_WARNING; cur_emerg = RST_EMERGENCY;
                cur_window = RST_WINDOW; lim_data = t_dist'(RST_LIMIT);
            end
            1: begin
                cur_safe = '0; cur_warn = '0; cur_emerg = '0; cur_window = '0; lim_data = '0;
            end
            2: begin
                cur_safe = '1; cur_warn = '1; cur_emerg = '1; cur_window = '1; lim_data = '1;
            end
            3: begin
                cur_safe = 16'd300; cur_warn = 16'd200; cur_emerg = 16'd100; cur_window = '1;
                lim_data = 16'h7FDF;
            end
            4: begin
                cur_safe = 16'd1000; cur_warn = 16'd3000; cur_emerg = 16'd500;
                cur_window = 16'd20; lim_data = '0;
            end
            5: begin
                cur_safe = t_dist'($urandom); cur_warn = t_dist'($urandom);
                cur_emerg = t_dist'($urandom); cur_window = t_dist'($urandom);
                lim_data = t_dist'($urandom);
            end
            6: begin
                cur_safe = t_dist'($urandom_range(1000));
                cur_warn = t_dist'($urandom_range(1000));
                cur_emerg = t_dist'($urandom_range(400));
                cur_window = t_dist'($urandom_range(200));
                lim_data = t_dist'($urandom);
            end
            default: begin
                cur_safe = 16'd300; cur_warn = 16'd200; cur_emerg = 16'd101;
                cur_window = 16'd1; lim_data = 16'd2;
            end
        endcase
        write_reg(CFG_SAFE, cur_safe);
        write_reg(CFG_WARNING, cur_warn);
        write_reg(CFG_EMERGENCY, cur_emerg);
        write_reg(CFG_WINDOW, cur_window);
        write_reg(CFG_LIMIT, lim_data);
        write_reg(CFG_LIMIT + t_cfg_idx'($urandom_range(1, 3)), t_dist'($urandom));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Distances cluster around the current thresholds so that every rule is exercised.
    function automatic t_dist pick_distance();
        t_dist thr_mm;
        case ($urandom_range(3))
            0: thr_mm = cur_safe;
            1: thr_mm = cur_warn;
            2: thr_mm = cur_emerg;
            default: thr_mm = cur_emerg >> 1;
        endcase
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return t_dist'($urandom);
            default: return thr_mm + t_dist'($urandom_range(4)) - t_dist'(2);
        endcase
    endfunction

    task automatic advance_clock(input bit small_only);
        int unsigned sel;
        sel = $urandom_range(99);
        if (small_only || sel < 70)
            ms_clock = ms_clock + $urandom_range(cur_window / 64 + 1);
        else if (sel < 93)
            ms_clock = ms_clock + $urandom_range(2 * cur_window + 2);
        else
            ms_clock = ms_clock + $urandom;
    endtask

    // Bursts of identical readings keep one direction repeating long enough for the
    // loop check to trip and the repeat count to saturate.
    task automatic run_random(input int count);
        t_dist f, l, r;
        int sent;
        int burst;
        int k;
        sent = 0;
        while (sent < count) begin
            burst = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 45);
            f = pick_distance();
            l = pick_distance();
            r = pick_distance();
            for (k = 0; k < burst && sent < count; k++) begin
                advance_clock(k > 0 && $urandom_range(9) != 0);
                if ($urandom_range(19) == 0) l = pick_distance();
                push_reading(f, l, r, ms_clock);
                sent++;
            end
        end
    endtask

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int ph;
        int k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        front_mm = '0;
        left_mm = '0;
        right_mm = '0;
        now_ms = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SAFE;
        cfg_data = '0;
        send_idle_pct = 28;
        recv_idle_pct = 49;
        cur_safe = RST_SAFE;
        cur_warn = RST_WARNING;
        cur_emerg = RST_EMERGENCY;
        cur_window = RST_WINDOW;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset settings.
        push_reading(16'd0, 16'd0, 16'd0, 32'd10);
        push_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd20);
        push_reading(16'd99, 16'hFFFF, 16'hFFFF, 32'd30);
        push_reading(16'd100, 16'd49, 16'hFFFF, 32'd40);
        push_reading(16'd100, 16'd50, 16'd49, 32'd50);
        push_reading(16'd301, 16'd199, 16'd301, 32'd60);
        push_reading(16'd301, 16'd301, 16'd199, 32'd70);
        push_reading(16'd300, 16'd201, 16'd200, 32'd80);
        push_reading(16'd300, 16'd200, 16'd201, 32'd90);
        push_reading(16'd300, 16'd200, 16'd200, 32'd100);
        push_reading(16'd200, 16'd150, 16'd150, 32'd110);
        for (k = 0; k < 10; k++)
            push_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, t_time'(200 + 10 * k));
        push_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd5400);
        push_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFF0);
        push_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0000_0005);
        wait_idle();

        ms_clock = $urandom;
        for (ph = 0; ph < 8; ph++) begin
            if (ph == 3) begin
                send_idle_pct = 49;
                recv_idle_pct = 28;
            end else if (ph == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_phase(ph);
            if (ph == 3 || ph == 6) begin
                @(posedge clk);
                long_hold_req = 1'b1;
            end
            run_random(250);
            wait_idle();
        end

        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
